FILE: rtl/assert_macros.svh
// Assertion macros used by the annotator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UCA_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
`define UCA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define UCA_ASSERT(label, expr, msg)
`define UCA_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

FILE: rtl/uca_pkg.sv
// Shared types, constants and helper functions for the code point annotator.
package uca_pkg;

    localparam int UNIT_W   = 16;
    localparam int CP_W     = 21;
    localparam int NDIG_W   = 3;
    localparam int CNT_W    = 4;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    localparam logic [CNT_W-1:0]  LAST_SLOT = 4'd15;
    localparam logic [NDIG_W-1:0] PRE_NDIG  = 3'd4;

    localparam logic [UNIT_W-1:0] CH_EQ    = 16'h003D;
    localparam logic [UNIT_W-1:0] CH_U     = 16'h0055;
    localparam logic [UNIT_W-1:0] CH_PLUS  = 16'h002B;
    localparam logic [UNIT_W-1:0] CH_SPACE = 16'h0020;

    localparam logic [CP_W-1:0] BMP_END = 21'h010000;

    // One accepted item, reduced to what the serializer emits:
    // an optional annotation of a held surrogate, the echoed unit,
    // and an optional trailing annotation.
    typedef struct packed {
        logic                has_pre;
        logic [UNIT_W-1:0]   pre_val;
        logic [UNIT_W-1:0]   echo_unit;
        logic                has_post;
        logic [CP_W-1:0]     post_val;
        logic [NDIG_W-1:0]   post_ndig;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [UNIT_W-1:0] hex_char(input logic [3:0] nib);
        logic [UNIT_W-1:0] c;
        if (nib < 4'd10) begin
            c = 16'h0030 + {12'd0, nib};
        end else begin
            c = 16'h0037 + {12'd0, nib};
        end
        return c;
    endfunction

    function automatic logic [NDIG_W-1:0] hex_digits(input logic [CP_W-1:0] v);
        logic [NDIG_W-1:0] n;
        if (v[20]) begin
            n = 3'd6;
        end else if (v[19:16] != 4'd0) begin
            n = 3'd5;
        end else if (v[15:12] != 4'd0) begin
            n = 3'd4;
        end else if (v[11:8] != 4'd0) begin
            n = 3'd3;
        end else begin
            n = 3'd2;
        end
        return n;
    endfunction

    function automatic logic is_high_sur(input logic [UNIT_W-1:0] u);
        return u[15:10] == 6'b110110;
    endfunction

    function automatic logic is_low_sur(input logic [UNIT_W-1:0] u);
        return u[15:10] == 6'b110111;
    endfunction

endpackage

FILE: rtl/uca_front.sv
// Front end: accepts code units, tracks a held high surrogate, builds descriptors.
module uca_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [uca_pkg::UNIT_W-1:0]   s_code_unit,
    input  logic                         s_end_of_text,
    input  uca_pkg::q_status_t           q_status,
    output logic                         q_push,
    output uca_pkg::desc_t               q_desc,
    output logic                         held_valid
);

    logic [uca_pkg::UNIT_W-1:0] held_high_reg, held_high_next;
    logic                       held_valid_reg, held_valid_next;
    logic                       u_low, u_high, pair;
    logic [uca_pkg::CP_W-1:0]   pair_cp;

    assign s_ready    = !q_status.full;
    assign q_push     = s_valid && s_ready;
    assign held_valid = held_valid_reg;

    always_comb begin
        u_low   = uca_pkg::is_low_sur(s_code_unit);
        u_high  = uca_pkg::is_high_sur(s_code_unit);
        pair    = held_valid_reg && u_low;
        pair_cp = {1'b0, held_high_reg[9:0], s_code_unit[9:0]} + uca_pkg::BMP_END;

        q_desc.has_pre   = held_valid_reg && !u_low;
        q_desc.pre_val   = held_high_reg;
        q_desc.echo_unit = s_code_unit;
        q_desc.has_post  = pair || !u_high || s_end_of_text;
        q_desc.post_val  = pair ? pair_cp : {5'd0, s_code_unit};
        q_desc.post_ndig = uca_pkg::hex_digits(q_desc.post_val);

        held_valid_next = held_valid_reg;
        held_high_next  = held_high_reg;
        if (q_push) begin
            held_valid_next = !pair && u_high && !s_end_of_text;
            held_high_next  = held_valid_next ? s_code_unit : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_high_reg  <= '0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_high_reg  <= held_high_next;
        end
    end

endmodule

FILE: rtl/uca_fifo.sv
// Short descriptor queue between the front end and the serializer.
module uca_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  uca_pkg::desc_t       push_desc,
    input  logic                 pop,
    output uca_pkg::desc_t       pop_desc,
    output uca_pkg::q_status_t   status,
    output logic [uca_pkg::QCNT_W-1:0] count
);

    uca_pkg::desc_t                 entry_reg [uca_pkg::QDEPTH];
    logic [uca_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [uca_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [uca_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;

    assign status.full  = (cnt_reg == uca_pkg::QCNT_W'(uca_pkg::QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign pop_desc     = entry_reg[rd_ptr_reg];
    assign count        = cnt_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + {{(uca_pkg::QCNT_W-1){1'b0}}, push}
                              - {{(uca_pkg::QCNT_W-1){1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: rtl/uca_back.sv
// Back end: serializes one descriptor into output units, one per cycle while m_ready is high.
module uca_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  uca_pkg::q_status_t           q_status,
    input  uca_pkg::desc_t               q_desc,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [uca_pkg::UNIT_W-1:0]   m_out_unit,
    output logic                         m_last_of_run
);

    typedef enum logic [2:0] {
        PH_EQ, PH_U, PH_PLUS, PH_DIG, PH_SP, PH_ECHO
    } phase_t;

    phase_t                          phase_reg;
    logic                            active_reg;
    logic                            in_post_reg;
    logic [uca_pkg::NDIG_W-1:0]      dig_reg;
    logic [uca_pkg::CNT_W-1:0]       cnt_reg;
    uca_pkg::desc_t                  job_reg;

    logic [uca_pkg::CP_W-1:0]        ann_val;
    logic [uca_pkg::CP_W-1:0]        shifted;
    logic [uca_pkg::NDIG_W-1:0]      ndig;
    logic                            natural_end;
    logic                            fire;
    logic                            done;

    always_comb begin
        ann_val = in_post_reg ? job_reg.post_val : {5'd0, job_reg.pre_val};
        shifted = ann_val >> {dig_reg, 2'b00};
        ndig    = in_post_reg ? job_reg.post_ndig : uca_pkg::PRE_NDIG;
        unique case (phase_reg)
            PH_EQ:   m_out_unit = uca_pkg::CH_EQ;
            PH_U:    m_out_unit = uca_pkg::CH_U;
            PH_PLUS: m_out_unit = uca_pkg::CH_PLUS;
            PH_DIG:  m_out_unit = uca_pkg::hex_char(shifted[3:0]);
            PH_SP:   m_out_unit = uca_pkg::CH_SPACE;
            PH_ECHO: m_out_unit = job_reg.echo_unit;
            default: m_out_unit = uca_pkg::CH_SPACE;
        endcase
        natural_end = (phase_reg == PH_ECHO && !job_reg.has_post)
                   || (phase_reg == PH_SP && in_post_reg);
        // An item never yields more than sixteen units; the rest is dropped.
        m_last_of_run = natural_end || (cnt_reg == uca_pkg::LAST_SLOT);
        m_valid       = active_reg;
        fire          = m_valid && m_ready;
        done          = !active_reg || (fire && m_last_of_run);
        q_pop         = done && !q_status.empty;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            phase_reg   <= PH_ECHO;
            in_post_reg <= 1'b0;
            dig_reg     <= '0;
            cnt_reg     <= '0;
        end else if (q_pop) begin
            active_reg  <= 1'b1;
            phase_reg   <= q_desc.has_pre ? PH_EQ : PH_ECHO;
            in_post_reg <= 1'b0;
            cnt_reg     <= '0;
        end else if (done) begin
            active_reg  <= 1'b0;
        end else if (fire) begin
            cnt_reg <= cnt_reg + 1'b1;
            unique case (phase_reg)
                PH_EQ:   phase_reg <= PH_U;
                PH_U:    phase_reg <= PH_PLUS;
                PH_PLUS: begin
                    phase_reg <= PH_DIG;
                    dig_reg   <= ndig - 1'b1;
                end
                PH_DIG: begin
                    if (dig_reg == '0) begin
                        phase_reg <= PH_SP;
                    end else begin
                        dig_reg <= dig_reg - 1'b1;
                    end
                end
                PH_SP:   phase_reg <= PH_ECHO;
                PH_ECHO: begin
                    phase_reg   <= PH_EQ;
                    in_post_reg <= 1'b1;
                end
                default: phase_reg <= PH_ECHO;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_desc;
        end
    end

endmodule

FILE: rtl/utf16_codepoint_annotator_top.sv
// Top level of the UTF-16 code point annotator.
//
// The input channel (s_valid, s_ready, s_code_unit, s_end_of_text) carries
// one UTF-16 code unit per transaction. Each unit is echoed on the output
// channel (m_valid, m_ready, m_out_unit, m_last_of_run), followed by the
// text "=U+", the code point in upper-case hex with at least two digits,
// and a space. A high surrogate is echoed at once and held; the next unit
// decides whether a surrogate pair or the lone surrogate is annotated.
// m_last_of_run marks the final output transaction caused by an input.
//
// An input transaction produces between 1 and 16 output transactions (7 for
// ASCII text, up to 9 for other units of the basic plane), issued one per
// cycle while m_ready is high, so the sustained input rate is set by the
// serializer.
// An accepted input is written to the queue and popped into the serializer
// once it is free. A two-entry descriptor queue lets the front end keep
// accepting input while the serializer is stalled; s_ready drops only when
// that queue is full. A receiver stall simply freezes the serializer.
// Reset (aresetn low at a clock edge) empties the queue, ends any output in
// progress and drops a held surrogate.
`include "assert_macros.svh"
module utf16_codepoint_annotator_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [uca_pkg::UNIT_W-1:0]   s_code_unit,
    input  logic                         s_end_of_text,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [uca_pkg::UNIT_W-1:0]   m_out_unit,
    output logic                         m_last_of_run
);

    uca_pkg::q_status_t                q_status;
    uca_pkg::desc_t                    push_desc;
    uca_pkg::desc_t                    pop_desc;
    logic                              q_push;
    logic                              q_pop;
    logic                              held_valid;
    logic [uca_pkg::QCNT_W-1:0]        q_count;

    // Front end: classification and surrogate tracking.
    uca_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_unit   (s_code_unit),
        .s_end_of_text (s_end_of_text),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_desc        (push_desc),
        .held_valid    (held_valid)
    );

    // Descriptor queue decoupling the two halves.
    uca_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .pop_desc  (pop_desc),
        .status    (q_status),
        .count     (q_count)
    );

    // Serializer: one output transaction per cycle while m_ready is high.
    uca_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .q_desc        (pop_desc),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_unit    (m_out_unit),
        .m_last_of_run (m_last_of_run)
    );

    `UCA_ASSERT(a_queue_bound, q_count <= uca_pkg::QCNT_W'(uca_pkg::QDEPTH), "queue overflow")
    `UCA_ASSERT(a_pop_nonempty, !q_pop || q_count != '0, "pop from empty queue")
    `UCA_ASSERT_NEXT(a_eot_flush, q_push && s_end_of_text, !held_valid, "surrogate held past end")

endmodule
